@@ src/bdq_pkg.sv @@
// Shared types and constants for the bounded double-ended queue.
package bdq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 128;
   localparam int unsigned DATA_W        = 32;
   localparam int unsigned OCC_W         = 8;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      op_type                     operation;
      logic signed [DATA_W-1:0]   data_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   data_out;
      status_type                 status;
      logic [OCC_W-1:0]           occupancy;
   } rsp_type;

endpackage

@@ src/bdq_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface bdq_req_if import bdq_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/bdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bounded_double_ended_queue.sv @@
// Bounded double-ended queue top level: circular buffer control and result stages.
//
// Usage: requests arrive on req_if (operation, data_in); each accepted request
// gives exactly one response on rsp_if (data_out, status, occupancy), in order.
// Push front/rear store data_in at the head or tail; pop front/rear return the
// head or tail entry. A push while full reports overflow, a pop while empty
// reports underflow; neither changes the queue and both return zero data.
// Occupancy is the entry count after the operation, low 8 bits.
// An accepted request is registered in the middle stage, then in the output
// stage, which drives rsp_if.valid.
// Throughput: one request per cycle while rsp_if accepts; the head pointer and
// count update in the cycle of the transfer and the entry RAM is read once per
// pop with one registered read port.
// Reset clears the head pointer, the count and both stage valids; RAM contents
// are left as they are and never read before written.
// When rsp_if.ready is low the response holds, the middle stage fills, and
// then req_if.ready drops until the output stage drains.
module bounded_double_ended_queue import bdq_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   bdq_req_if.sink      req_if,
   bdq_rsp_if.source    rsp_if
);

   localparam int unsigned PtrW   = $clog2(DEPTH);
   localparam int unsigned CountW = $clog2(DEPTH + 1);
   localparam int unsigned SumW   = CountW + 1;

   logic [PtrW-1:0]   head_ff, head_in;
   logic [CountW-1:0] count_ff, count_in;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_rd_ff, s1_rd_in;
   status_type        s1_status_ff, s1_status_in;
   logic [OCC_W-1:0]  s1_occ_ff, s1_occ_in;

   logic                      s2_valid_ff, s2_valid_in;
   logic signed [DATA_W-1:0]  s2_data_ff, s2_data_in;
   status_type                s2_status_ff, s2_status_in;
   logic [OCC_W-1:0]          s2_occ_ff, s2_occ_in;

   logic              s1_adv, req_xfer;
   logic              full, empty;
   logic [PtrW-1:0]   head_dec, head_inc, tail_pos, last_pos;
   logic [SumW-1:0]   tail_sum, last_sum;
   logic [CountW+OCC_W-1:0] count_ext;

   logic              wr_en, rd_en;
   logic [PtrW-1:0]   wr_addr, rd_addr;
   logic [DATA_W-1:0] rd_data;

   assign s1_adv   = !s2_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign req_xfer = req_if.valid && req_if.ready;

   assign full  = (count_ff == CountW'(DEPTH));
   assign empty = (count_ff == '0);

   assign head_dec = (head_ff == '0) ? PtrW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == PtrW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign tail_sum = SumW'(head_ff) + SumW'(count_ff);
   assign last_sum = tail_sum - 1'b1;
   assign tail_pos = (tail_sum >= SumW'(DEPTH)) ? PtrW'(tail_sum - SumW'(DEPTH))
                                                : PtrW'(tail_sum);
   assign last_pos = (last_sum >= SumW'(DEPTH)) ? PtrW'(last_sum - SumW'(DEPTH))
                                                : PtrW'(last_sum);

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      wr_addr      = head_dec;
      rd_addr      = head_ff;
      s1_status_in = ST_OK;
      case (req_if.payload.operation)
         OP_PUSH_FRONT: begin
            if (full) begin
               s1_status_in = ST_OVERFLOW;
            end else begin
               wr_en    = req_xfer;
               wr_addr  = head_dec;
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_REAR: begin
            if (full) begin
               s1_status_in = ST_OVERFLOW;
            end else begin
               wr_en    = req_xfer;
               wr_addr  = tail_pos;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               s1_status_in = ST_UNDERFLOW;
            end else begin
               rd_en    = req_xfer;
               rd_addr  = head_ff;
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            if (empty) begin
               s1_status_in = ST_UNDERFLOW;
            end else begin
               rd_en    = req_xfer;
               rd_addr  = last_pos;
               count_in = count_ff - 1'b1;
            end
         end
      endcase
   end

   assign count_ext = {{OCC_W{1'b0}}, count_in};
   assign s1_occ_in = count_ext[OCC_W-1:0];
   assign s1_rd_in  = (req_if.payload.operation == OP_POP_FRONT ||
                       req_if.payload.operation == OP_POP_REAR) && !empty;

   assign s1_valid_in = req_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = (s1_adv && s1_valid_ff) ? 1'b1
                      : (rsp_if.ready ? 1'b0 : s2_valid_ff);
   assign s2_data_in   = s1_rd_ff ? $signed(rd_data) : '0;
   assign s2_status_in = s1_status_ff;
   assign s2_occ_in    = s1_occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_rd_ff     <= s1_rd_in;
         s1_status_ff <= s1_status_in;
         s1_occ_ff    <= s1_occ_in;
      end
      if (s1_adv && s1_valid_ff) begin
         s2_data_ff   <= s2_data_in;
         s2_status_ff <= s2_status_in;
         s2_occ_ff    <= s2_occ_in;
      end
   end

   bdq_ram #(
      .Width (DATA_W),
      .Depth (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.payload.data_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_if.valid = s2_valid_ff;
   assign rsp_if.payload.data_out  = s2_data_ff;
   assign rsp_if.payload.status    = s2_status_ff;
   assign rsp_if.payload.occupancy = s2_occ_ff;

endmodule

@@ src/bdq_checker.sv @@
// Port-level checker for the bounded double-ended queue, bound to the top level.
module bdq_checker import bdq_pkg::*; #(
   parameter int unsigned Depth = DEPTH_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   logic [1:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer   = req_valid && req_ready;
   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_pending_max: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two requests in flight");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a pending request");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_UNDERFLOW |->
         rsp_payload.data_out == '0 && rsp_payload.occupancy == '0)
      else $error("underflow with data or nonzero occupancy");

   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_OVERFLOW |->
         rsp_payload.data_out == '0 && rsp_payload.occupancy == OCC_W'(Depth))
      else $error("overflow with data or not full");

endmodule

bind bounded_double_ended_queue bdq_checker #(.Depth(DEPTH)) u_bdq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
